// File: hdl/rfmf_pkg.sv
// Shared types and constants for the request queue with match flush.
package rfmf_pkg;

	localparam int HANDLE_W = 16;
	localparam int FILL_W   = 5;

	typedef enum logic [1:0] {
		OP_POP   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_FLUSH = 2'd2,
		OP_ADD   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 opcode;
		logic [HANDLE_W-1:0] request_code;
		logic [HANDLE_W-1:0] primary_object;
		logic [HANDLE_W-1:0] secondary_object;
		logic [HANDLE_W-1:0] match_key;
	} req_t;

	typedef struct packed {
		logic                entry_found;
		logic [HANDLE_W-1:0] out_request;
		logic [HANDLE_W-1:0] out_primary;
		logic [HANDLE_W-1:0] out_secondary;
		logic                add_dropped;
		logic [FILL_W-1:0]   fill_level;
	} rsp_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] req;
		logic [HANDLE_W-1:0] pri;
		logic [HANDLE_W-1:0] sec;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_DELIVER
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic do_pop;
		logic do_clear;
		logic do_add;
		logic fl_start;
		logic fl_step;
		logic fl_done;
		logic deliver;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fl_drained;
		logic out_free;
	} status_t;

endpackage

// File: hdl/rfmf_ctrl.sv
// Controller state machine: accepts one word, sequences flush, hands result to output.
module rfmf_ctrl
	import rfmf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  op_t     opcode,
	output logic    req_stall,
	output cmd_t    cmd,
	input  status_t status
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					case (opcode)
						OP_POP:   cmd.do_pop   = 1'b1;
						OP_CLEAR: cmd.do_clear = 1'b1;
						OP_FLUSH: cmd.fl_start = 1'b1;
						OP_ADD:   cmd.do_add   = 1'b1;
						default:  cmd.do_add   = 1'b1;
					endcase
					state_d = (opcode == OP_FLUSH) ? ST_FLUSH : ST_DELIVER;
				end
			end
			ST_FLUSH: begin
				cmd.fl_step = 1'b1;
				if (status.fl_drained) begin
					cmd.fl_done = 1'b1;
					state_d     = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (status.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/rfmf_dp.sv
// Datapath: circular entry store, pointers, flush compaction pipe and output register.
module rfmf_dp
	import rfmf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  req_t    req,
	output status_t status,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output rsp_t    rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
		return s[PW-1:0];
	endfunction

	entry_t mem [QUEUE_DEPTH];

	logic [PW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_q;
	logic [CW-1:0]       wr_q;
	logic                fl_vld_s1;
	entry_t              rd_data_s1;
	logic [HANDLE_W-1:0] key_q;
	logic                res_found_q;
	logic                res_dropped_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic          empty, full, keep, rd_more;
	logic          mem_we, mem_re;
	logic [PW-1:0] wr_addr, rd_addr;
	entry_t        wr_data;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign rd_more = (rd_q < count_q);
	assign keep    = !((rd_data_s1.pri == key_q) || (rd_data_s1.sec == key_q));

	assign status.fl_drained = !rd_more && !fl_vld_s1;
	assign status.out_free   = !rsp_valid_q || !rsp_stall;

	// single write port: append at tail, or compacted survivor during flush
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = wrap_add(head_q, count_q);
		wr_data = '{req: req.request_code, pri: req.primary_object,
			sec: req.secondary_object};
		if (cmd.do_add && !full) begin
			mem_we = 1'b1;
		end else if (cmd.fl_step && fl_vld_s1 && keep) begin
			mem_we  = 1'b1;
			wr_addr = wrap_add(head_q, wr_q);
			wr_data = rd_data_s1;
		end
	end

	assign mem_re  = (cmd.do_pop && !empty) || (cmd.fl_step && rd_more);
	assign rd_addr = cmd.do_pop ? head_q : wrap_add(head_q, rd_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (cmd.fl_start) begin
			key_q <= req.match_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			rd_q          <= '0;
			wr_q          <= '0;
			fl_vld_s1     <= 1'b0;
			res_found_q   <= 1'b0;
			res_dropped_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				res_found_q   <= cmd.do_pop && !empty;
				res_dropped_q <= cmd.do_add && full;
			end
			if (cmd.do_pop && !empty) begin
				head_q  <= wrap_add(head_q, CW'(1));
				count_q <= count_q - CW'(1);
			end
			if (cmd.do_clear) begin
				count_q <= '0;
			end
			if (cmd.do_add && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.fl_start) begin
				rd_q      <= '0;
				wr_q      <= '0;
				fl_vld_s1 <= 1'b0;
			end
			if (cmd.fl_step) begin
				fl_vld_s1 <= rd_more;
				if (rd_more) begin
					rd_q <= rd_q + CW'(1);
				end
				if (fl_vld_s1 && keep) begin
					wr_q <= wr_q + CW'(1);
				end
			end
			if (cmd.fl_done) begin
				count_q <= wr_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			rsp_q.entry_found   <= res_found_q;
			rsp_q.out_request   <= res_found_q ? rd_data_s1.req : '0;
			rsp_q.out_primary   <= res_found_q ? rd_data_s1.pri : '0;
			rsp_q.out_secondary <= res_found_q ? rd_data_s1.sec : '0;
			rsp_q.add_dropped   <= res_dropped_q;
			rsp_q.fill_level    <= FILL_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fl_step |-> (wr_q <= rd_q))
		else $error("flush write pointer overtook read pointer");

	a_flush_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fl_done |=> (count_q <= $past(count_q)))
		else $error("flush grew the queue");

	a_full_add_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_add && full) |=> $stable(count_q) && $stable(head_q))
		else $error("dropped add changed the queue");

	a_deliver_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwrote a stalled word");
`endif

endmodule

// File: hdl/request_fifo_with_match_flush.sv
// Top level of the ordered request queue with selective flush.
//
// Request channel (req_valid, req_stall, req): one word per operation:
// pop oldest, clear, flush entries matching a key, or add an entry.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per request,
// in request order, carrying the popped entry, the drop flag and fill level.
// A word moves when valid is high and stall is low.
// Add, pop and clear: the request is handled in the edge that accepts it, and
// the result is loaded into the output register once that register is free.
// Flush walks the stored entries through the single read port of the store,
// one per cycle, and compacts survivors through the write port; the result is
// loaded once the walk has drained and the output register is free.
// One request is in flight at a time; req_stall is high from acceptance
// until its result sits in the output register. A stalled response holds,
// and the next request is taken meanwhile but its result waits.
// Reset empties the queue and drops any pending word; store contents are
// left as they are and are never read before being written.
module request_fifo_with_match_flush
	import rfmf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t    cmd;
	status_t status;

	rfmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.req_stall (req_stall),
		.cmd       (cmd),
		.status    (status)
	);

	rfmf_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: test/tb.sv
// Testbench for the request queue with match flush: self-checking, directed tests and random traffic.
`timescale 1ns / 100ps

module tb;
	import rfmf_pkg::*;

	localparam int DEPTH         = 16;
	localparam int RANDOM_WORDS  = 1350;
	localparam int IDLE_LIMIT    = 1000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_PRINTS    = 20;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	entry_t queue_model[$];
	rsp_t   expected_rsp[$];
	rsp_t   want_rsp;

	int mismatches     = 0;
	int words_sent     = 0;
	int words_checked  = 0;
	int pops_with_data = 0;
	int adds_dropped   = 0;
	int flush_hits     = 0;
	int times_full     = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;
	int stall_mode     = 0;
	int stall_phase    = 0;
	int stall_hold     = 0;
	logic [HANDLE_W-1:0] pool[4];

	request_fifo_with_match_flush #(.QUEUE_DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// applies one word to the queue model and returns the response it should give
	function automatic rsp_t queue_response(input req_t w);
		rsp_t   r;
		entry_t kept[$];
		entry_t e;
		r = '0;
		case (w.opcode)
		OP_POP: begin
			if (queue_model.size() != 0) begin
				r.entry_found = 1'b1;
				{r.out_request, r.out_primary, r.out_secondary} = queue_model.pop_front();
				pops_with_data++;
			end
		end
		OP_CLEAR: begin
			queue_model.delete();
		end
		OP_FLUSH: begin
			foreach (queue_model[i])
				if (queue_model[i].pri != w.match_key && queue_model[i].sec != w.match_key)
					kept.insert(kept.size(), queue_model[i]);
			if (kept.size() != queue_model.size())
				flush_hits++;
			queue_model = kept;
		end
		default: begin
			if (queue_model.size() >= DEPTH) begin
				r.add_dropped = 1'b1;
				adds_dropped++;
			end else begin
				e = '{req: w.request_code, pri: w.primary_object, sec: w.secondary_object};
				queue_model.insert(queue_model.size(), e);
				if (queue_model.size() == DEPTH)
					times_full++;
			end
		end
		endcase
		r.fill_level = FILL_W'(queue_model.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t: %s at word %0d: got 0x%0h, expected 0x%0h",
				$realtime, what, words_checked, got, want);
		mismatches++;
	endtask

	// request and response monitor, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				words_checked++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("response with nothing outstanding",
						32'(rsp.out_request), 32'd0);
				end else begin
					want_rsp = expected_rsp.pop_front();
					if (rsp.entry_found !== want_rsp.entry_found)
						report_mismatch("entry_found", 32'(rsp.entry_found),
							32'(want_rsp.entry_found));
					if (rsp.out_request !== want_rsp.out_request)
						report_mismatch("out_request", 32'(rsp.out_request),
							32'(want_rsp.out_request));
					if (rsp.out_primary !== want_rsp.out_primary)
						report_mismatch("out_primary", 32'(rsp.out_primary),
							32'(want_rsp.out_primary));
					if (rsp.out_secondary !== want_rsp.out_secondary)
						report_mismatch("out_secondary", 32'(rsp.out_secondary),
							32'(want_rsp.out_secondary));
					if (rsp.add_dropped !== want_rsp.add_dropped)
						report_mismatch("add_dropped", 32'(rsp.add_dropped),
							32'(want_rsp.add_dropped));
					if (rsp.fill_level !== want_rsp.fill_level)
						report_mismatch("fill_level", 32'(rsp.fill_level),
							32'(want_rsp.fill_level));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.insert(expected_rsp.size(), queue_response(req));

			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// response back-pressure: phases of no stall, light random stall, long runs
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_phase = $urandom_range(150, 20);
			stall_mode  = $urandom_range(2, 0);
		end
		stall_phase--;
		if (stall_hold != 0) begin
			stall_hold--;
		end else begin
			case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(3, 0) == 0);
			default: begin
				rsp_stall <= ~rsp_stall;
				stall_hold = $urandom_range(12, 0);
			end
			endcase
		end
	end

	// random handle value
	function automatic logic [HANDLE_W-1:0] rnd_handle();
		return HANDLE_W'($urandom);
	endfunction

	function automatic req_t mk(input op_t op, input logic [HANDLE_W-1:0] rq,
			input logic [HANDLE_W-1:0] pr, input logic [HANDLE_W-1:0] sc,
			input logic [HANDLE_W-1:0] key);
		req_t w;
		w.opcode           = op;
		w.request_code     = rq;
		w.primary_object   = pr;
		w.secondary_object = sc;
		w.match_key        = key;
		return w;
	endfunction

	// one word; valid stays high across a burst and drops for the gap after it
	task automatic send_word(input req_t w);
		int gap;
		@(negedge clk);
		req_valid = 1'b1;
		req       = w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		words_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(30, 0);
			gap = ($urandom_range(3, 0) == 0) ? $urandom_range(25, 8) : $urandom_range(3, 1);
			@(negedge clk);
			req_valid = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic test_empty_queue();
		send_word(mk(OP_POP, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
		send_word(mk(OP_CLEAR, rnd_handle(), rnd_handle(), rnd_handle(), rnd_handle()));
		send_word(mk(OP_FLUSH, rnd_handle(), rnd_handle(), rnd_handle(), 16'h0000));
	endtask

	task automatic test_add_flush_pop();
		send_word(mk(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'h0000));
		send_word(mk(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'hffff));
		send_word(mk(OP_ADD, 16'h5555, 16'haaaa, 16'h1234, 16'h5555));
		send_word(mk(OP_ADD, 16'haaaa, 16'h0007, 16'haaaa, 16'h0000));
		// key hits the primary of one entry and the secondary of the other
		send_word(mk(OP_FLUSH, rnd_handle(), rnd_handle(), rnd_handle(), 16'haaaa));
		send_word(mk(OP_FLUSH, rnd_handle(), rnd_handle(), rnd_handle(), 16'h0001));
		send_word(mk(OP_POP, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_word(mk(OP_POP, rnd_handle(), rnd_handle(), rnd_handle(), rnd_handle()));
		send_word(mk(OP_POP, rnd_handle(), rnd_handle(), rnd_handle(), rnd_handle()));
	endtask

	task automatic test_flush_all_and_clear();
		send_word(mk(OP_ADD, 16'h0101, 16'h00c3, 16'h9999, rnd_handle()));
		send_word(mk(OP_ADD, 16'h0102, 16'h8888, 16'h00c3, rnd_handle()));
		send_word(mk(OP_ADD, 16'h0103, 16'h00c3, 16'h00c3, rnd_handle()));
		send_word(mk(OP_FLUSH, rnd_handle(), rnd_handle(), rnd_handle(), 16'h00c3));
		send_word(mk(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, rnd_handle()));
		send_word(mk(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, rnd_handle()));
		send_word(mk(OP_CLEAR, rnd_handle(), rnd_handle(), rnd_handle(), rnd_handle()));
		send_word(mk(OP_POP, rnd_handle(), rnd_handle(), rnd_handle(), rnd_handle()));
	endtask

	// sequences: fill past full, drain past empty, flush on shared handles, clear, noise
	task automatic test_random_traffic();
		int kind;
		int n;
		logic [HANDLE_W-1:0] pr;
		logic [HANDLE_W-1:0] sc;
		int stop_at;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			kind = $urandom_range(9, 0);
			foreach (pool[i])
				case ($urandom_range(5, 0))
				0: pool[i] = '0;
				1: pool[i] = '1;
				default: pool[i] = rnd_handle();
				endcase
			if (kind <= 2) begin
				n = $urandom_range(22, 8);
				repeat (n) begin
					pr = $urandom_range(1, 0) ? pool[2'($urandom_range(3, 0))] : rnd_handle();
					sc = $urandom_range(1, 0) ? pool[2'($urandom_range(3, 0))] : rnd_handle();
					if ($urandom_range(4, 0) == 0)
						send_word(mk(OP_POP, rnd_handle(), rnd_handle(), rnd_handle(),
							rnd_handle()));
					else
						send_word(mk(OP_ADD, rnd_handle(), pr, sc, rnd_handle()));
				end
			end else if (kind <= 4) begin
				repeat ($urandom_range(18, 3))
					send_word(mk(OP_POP, rnd_handle(), rnd_handle(), rnd_handle(),
						rnd_handle()));
			end else if (kind <= 7) begin
				repeat ($urandom_range(8, 0)) begin
					pr = $urandom_range(3, 0) != 0 ? pool[2'($urandom_range(3, 0))]
						: rnd_handle();
					sc = $urandom_range(3, 0) != 0 ? pool[2'($urandom_range(3, 0))]
						: rnd_handle();
					send_word(mk(OP_ADD, rnd_handle(), pr, sc, rnd_handle()));
				end
				repeat ($urandom_range(2, 1))
					send_word(mk(OP_FLUSH, rnd_handle(), rnd_handle(), rnd_handle(),
						$urandom_range(4, 0) != 0 ? pool[2'($urandom_range(3, 0))]
						: rnd_handle()));
			end else if (kind == 8) begin
				send_word(mk(OP_CLEAR, rnd_handle(), rnd_handle(), rnd_handle(),
					rnd_handle()));
			end else begin
				repeat ($urandom_range(10, 4))
					send_word(mk(op_t'($urandom_range(3, 0)), rnd_handle(), rnd_handle(),
						rnd_handle(), rnd_handle()));
			end
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_add_flush_pop();
		test_flush_all_and_clear();
		test_random_traffic();

		@(negedge clk);
		req_valid = 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d requests, checked %0d responses, %0d field mismatches.",
			words_sent, words_checked, mismatches);
		$display("Queue full %0d times; %0d pops with data, %0d adds dropped, %0d hit flushes.",
			times_full, pops_with_data, adds_dropped, flush_hits);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/rfmf_pkg.sv
hdl/rfmf_ctrl.sv
hdl/rfmf_dp.sv
hdl/request_fifo_with_match_flush.sv
test/tb.sv
